/* src/seqr_pkg.sv */
package seqr_pkg;

  localparam int CAPACITY = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef logic [31:0]      seq_t;
  typedef logic [31:0]      payload_t;
  typedef logic [CNT_W-1:0] count_t;

  // opcodes of an input item
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // push status codes
  localparam logic [1:0] ST_ACCEPTED      = 2'd0;
  localparam logic [1:0] ST_OUT_OF_WINDOW = 2'd1;
  localparam logic [1:0] ST_DUPLICATE     = 2'd2;
  localparam logic [1:0] ST_FULL          = 2'd3;

  typedef struct packed {
    seq_t     seq;
    payload_t payload;
  } entry_t;

  typedef struct packed {
    logic     opcode;
    seq_t     command_sequence;
    payload_t command_payload;
  } in_item_t;

  typedef struct packed {
    logic [1:0] push_status;
    logic       has_command;
    seq_t       out_sequence;
    payload_t   out_payload;
    logic       is_late;
    logic       used_fallback;
  } out_item_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_POP
  } cell_op_t;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic     cmp;
    cell_op_t op;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_APPLY
  } state_t;

endpackage

/* src/sequence_reorder_inbox.sv */
// channel | fields                                            | handshake
// item    | opcode, command_sequence, command_payload         | item_valid / item_ready
// result  | push_status, has_command, out_sequence,           | result_valid / result_ready
//         | out_payload, is_late, used_fallback               |
//
// each item goes through capture, a parallel compare in every cell of the chain,
// then apply (insert, pop or reject) and the load of the result register.
// the next item is taken as soon as the block returns to idle, while the
// result register may still hold an untaken result; apply waits on that register.
// reset clears the fill count and the last-consumed state; cells need no clearing.
module sequence_reorder_inbox (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  seqr_pkg::in_item_t  item,
  output logic                result_valid,
  input  logic                result_ready,
  output seqr_pkg::out_item_t result
);
  import seqr_pkg::*;

  state_t    state;
  state_t    state_next;
  in_item_t  req;
  count_t    count;
  seq_t      last_seq;
  entry_t    last_cmd;
  logic      have_last;
  logic      oow_q;
  logic      stale_q;
  cell_ctl_t ctl;
  entry_t    head;
  logic      dup;
  logic      apply;
  logic [1:0] status;
  out_item_t res_next;
  logic      full;

  seqr_chain u_chain (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .count     (count),
    .req_seq   (req.command_sequence),
    .new_entry ({req.command_sequence, req.command_payload}),
    .head      (head),
    .dup       (dup)
  );

  assign full = count == CNT_W'(CAPACITY);

  // push status in priority order
  always_comb begin
    priority if (have_last && oow_q) begin
      status = ST_OUT_OF_WINDOW;
    end else if ((have_last && stale_q) || dup) begin
      status = ST_DUPLICATE;
    end else if (full) begin
      status = ST_FULL;
    end else begin
      status = ST_ACCEPTED;
    end
  end

  // next state, cell control and result
  always_comb begin
    state_next = state;
    item_ready = 1'b0;
    apply      = 1'b0;
    ctl.cmp    = 1'b0;
    ctl.op     = CELL_HOLD;
    res_next   = '0;
    unique case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        ctl.cmp    = 1'b1;
        state_next = S_APPLY;
      end
      S_APPLY: begin
        if (!result_valid || result_ready) begin
          apply      = 1'b1;
          state_next = S_IDLE;
          if (req.opcode == OP_PUSH) begin
            res_next.push_status = status;
            if (status == ST_ACCEPTED) begin
              ctl.op = CELL_INSERT;
            end
          end else if (count == '0) begin
            res_next.is_late = 1'b1;
            if (have_last) begin
              res_next.has_command   = 1'b1;
              res_next.out_sequence  = last_cmd.seq;
              res_next.out_payload   = last_cmd.payload;
              res_next.used_fallback = 1'b1;
            end
          end else begin
            ctl.op               = CELL_POP;
            res_next.has_command  = 1'b1;
            res_next.out_sequence = head.seq;
            res_next.out_payload  = head.payload;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // captured item and window flags
  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      req <= item;
    end
    if (state == S_CMP) begin
      if (last_seq >= 32'(CAPACITY)) begin
        oow_q <= req.command_sequence <= (last_seq - 32'(CAPACITY));
      end else begin
        oow_q <= req.command_sequence == 32'd0;
      end
      stale_q <= req.command_sequence <= last_seq;
    end
  end

  // fill count and last consumed command
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      last_seq  <= '0;
      last_cmd  <= '0;
      have_last <= 1'b0;
    end else if (apply) begin
      if (ctl.op == CELL_INSERT) begin
        count <= count + CNT_W'(1);
      end else if (ctl.op == CELL_POP) begin
        count     <= count - CNT_W'(1);
        last_seq  <= head.seq;
        last_cmd  <= head;
        have_last <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (apply) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
    if (apply) begin
      result <= res_next;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("fill count beyond capacity");

  a_result_from_apply: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == S_APPLY))
    else $error("result raised outside apply");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    (apply && ctl.op == CELL_INSERT) |=> (count == $past(count) + CNT_W'(1)))
    else $error("insert did not grow fill count");

  a_pop_tracks_last: assert property (@(posedge clk) disable iff (rst)
    (apply && ctl.op == CELL_POP) |=> (have_last && last_seq == result.out_sequence))
    else $error("pop did not record last consumed command");
`endif

endmodule

/* src/seqr_cell.sv */
module seqr_cell (
  input  logic              clk,
  input  seqr_pkg::cell_ctl_t ctl,
  input  logic              occ,
  input  seqr_pkg::seq_t    req_seq,
  input  seqr_pkg::entry_t  new_entry,
  input  seqr_pkg::entry_t  left_entry,
  input  logic              left_ins,
  input  seqr_pkg::entry_t  right_entry,
  output seqr_pkg::entry_t  entry,
  output logic              ins,
  output logic              eq
);
  import seqr_pkg::*;

  entry_t slot;
  logic   eq_q;
  logic   lt_q;

  // compare flags against the pending sequence
  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      eq_q <= occ && (slot.seq == req_seq);
      lt_q <= occ && (slot.seq < req_seq);
    end
  end

  // shift in from the left on insert, from the right on pop
  always_ff @(posedge clk) begin
    unique case (ctl.op)
      CELL_HOLD: begin
      end
      CELL_INSERT: begin
        if (ins) begin
          slot <= left_ins ? left_entry : new_entry;
        end
      end
      CELL_POP: begin
        slot <= right_entry;
      end
      default: begin
      end
    endcase
  end

  assign ins   = !lt_q;
  assign eq    = eq_q;
  assign entry = slot;

endmodule

/* src/seqr_chain.sv */
module seqr_chain (
  input  logic                clk,
  input  logic                rst,
  input  seqr_pkg::cell_ctl_t ctl,
  input  seqr_pkg::count_t    count,
  input  seqr_pkg::seq_t      req_seq,
  input  seqr_pkg::entry_t    new_entry,
  output seqr_pkg::entry_t    head,
  output logic                dup
);
  import seqr_pkg::*;

  entry_t               entries [CAPACITY];
  logic [CAPACITY-1:0]  ins;
  logic [CAPACITY-1:0]  eq;
  logic [CAPACITY-1:0]  occ;

  // row of cells, cell 0 holds the lowest sequence
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign occ[i] = CNT_W'(i) < count;
    seqr_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occ         (occ[i]),
      .req_seq     (req_seq),
      .new_entry   (new_entry),
      .left_entry  ((i == 0) ? new_entry : entries[(i == 0) ? 0 : i - 1]),
      .left_ins    ((i == 0) ? 1'b0 : ins[(i == 0) ? 0 : i - 1]),
      .right_entry ((i == CAPACITY - 1) ? entries[i]
                                         : entries[(i == CAPACITY - 1) ? i : i + 1]),
      .entry       (entries[i]),
      .ins         (ins[i]),
      .eq          (eq[i])
    );
  end

  assign head = entries[0];
  assign dup  = |eq;

`ifndef SYNTHESIS
  // the first two held entries stay strictly ascending at the head of the chain
  a_sorted: assert property (@(posedge clk) disable iff (rst)
    (count >= CNT_W'(2)) |-> (entries[0].seq < entries[1].seq))
    else $error("chain head out of order");
`endif

endmodule
